/* hdl/etsc_pkg.sv */
// ----------------------------------------------------------------------------
// Encoder timer/stopwatch control package
// Item types, mode and register codes, and constants shared by the block.
// ----------------------------------------------------------------------------
package etsc_pkg;

  typedef enum logic [2:0] {
    MODE_CLOCK     = 3'd0,
    MODE_TIMER     = 3'd1,
    MODE_STOPWATCH = 3'd2,
    MODE_REMINDERS = 3'd3,
    MODE_SETTINGS  = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    REG_HOLD_LIMIT   = 3'd0,
    REG_DEBOUNCE     = 3'd1,
    REG_ACCEL_WINDOW = 3'd2,
    REG_ACCEL_FACTOR = 3'd3,
    REG_ALARM_REPEAT = 3'd4
  } cfg_reg_e;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [15:0] LongPressReset   = 16'd600;
  localparam logic [15:0] DebounceReset    = 16'd250;
  localparam logic [15:0] AccelWindowReset = 16'd80;
  localparam logic [3:0]  AccelFactorReset = 4'd5;
  localparam logic [15:0] AlarmRepeatReset = 16'd1200;

  localparam logic [22:0] MsPerMin      = 23'd60000;
  localparam logic [6:0]  MinutesMin    = 7'd1;
  localparam logic [6:0]  MinutesMax    = 7'd99;
  localparam logic [6:0]  MinutesReset  = 7'd5;
  localparam logic [22:0] RemainReset   = 23'd300000;
  localparam logic [31:0] AlarmBeepMs   = 32'd200;
  localparam logic [31:0] TurnBeepMs    = 32'd15;
  localparam logic [31:0] ReleaseBeepMs = 32'd40;

  typedef struct packed {
    logic enc_a;
    logic enc_b;
    logic button_down;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [6:0]  timer_minutes;
    logic [22:0] timer_remaining_ms;
    logic        timer_running;
    logic        timer_editing;
    logic        alarm_active;
    logic [31:0] stopwatch_ms;
    logic        stopwatch_running;
    logic        buzzer;
    logic        button_held;
  } out_item_t;

endpackage

/* hdl/encoder_timer_stopwatch_control_top.sv */
// ----------------------------------------------------------------------------
// Encoder timer/stopwatch control
// Millisecond-tick controller: quadrature decoding, mode selection, countdown
// timer, stopwatch, button press timing and buzzer control.
// ----------------------------------------------------------------------------
// Each input item is one millisecond tick with the two encoder pins and the
// button level; each item yields exactly one result item holding the state
// after that tick. The whole tick update is one combinational pass into the
// state registers, which also serve as the result register, so a new item is
// taken every cycle unless the result from the previous item is still
// stalled. Configuration writes are always ready and take effect on the next
// item.
module encoder_timer_stopwatch_control_top
  import etsc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  logic [15:0] hold_limit_q, debounce_q, accel_window_q, alarm_repeat_q;
  logic [3:0]  accel_factor_q;

  logic [31:0] now_q, last_move_q, last_alarm_q, sw_q, press_start_q;
  logic [31:0] last_short_q, beep_end_q;
  logic [31:0] last_move_d, last_alarm_d, sw_d, press_start_d;
  logic [31:0] last_short_d, beep_end_d;
  logic [3:0]  quad_q, quad_d;
  logic signed [2:0] detent_q, detent_d;
  mode_e       mode_q, mode_d;
  logic [6:0]  minutes_q, minutes_d;
  logic [22:0] remain_q, remain_d;
  logic        count_run_q, count_run_d, edit_q, edit_d, alarm_q, alarm_d;
  logic        sw_run_q, sw_run_d, held_q, held_d, beep_on_q, beep_on_d;
  logic        out_valid_q;

  logic              in_accept;
  logic signed [2:0] acc;
  logic              move_up, move_dn, move, fast, edit_turn;
  logic [31:0]       move_gap, hold_dur, short_gap, alarm_gap;
  logic [3:0]        step_mag;
  logic signed [8:0] min_sum;
  logic [6:0]        min_clamped;
  logic [22:0]       reload_ms;
  logic              release_evt, hold_is_long, short_ok;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_limit_q   <= LongPressReset;
      debounce_q     <= DebounceReset;
      accel_window_q <= AccelWindowReset;
      accel_factor_q <= AccelFactorReset;
      alarm_repeat_q <= AlarmRepeatReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_HOLD_LIMIT:   hold_limit_q   <= cfg_data_i;
        REG_DEBOUNCE:     debounce_q     <= cfg_data_i;
        REG_ACCEL_WINDOW: accel_window_q <= cfg_data_i;
        REG_ACCEL_FACTOR: accel_factor_q <= cfg_data_i[3:0];
        REG_ALARM_REPEAT: alarm_repeat_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Quadrature decoding: two valid transitions in one direction make a step.
  always_comb begin
    quad_d = {quad_q[1:0], in_data_i.enc_a, in_data_i.enc_b};
    unique case (quad_d)
      4'd13, 4'd4, 4'd2, 4'd11: acc = detent_q + 3'sd1;
      4'd14, 4'd7, 4'd1, 4'd8:  acc = detent_q - 3'sd1;
      default:                  acc = detent_q;
    endcase
    move_up  = (acc == 3'sd2);
    move_dn  = (acc == -3'sd2);
    move     = move_up || move_dn;
    detent_d = move ? 3'sd0 : acc;
  end

  // Turn handling: minute adjust with clamp, and the matching reload value.
  always_comb begin
    move_gap  = now_q - last_move_q;
    fast      = move_gap < {16'd0, accel_window_q};
    step_mag  = fast ? accel_factor_q : 4'd1;
    edit_turn = (mode_q == MODE_TIMER) && edit_q && !count_run_q;
    if (move_up) begin
      min_sum = $signed({2'b00, minutes_q}) + $signed({5'd0, step_mag});
    end else begin
      min_sum = $signed({2'b00, minutes_q}) - $signed({5'd0, step_mag});
    end
    if (min_sum < $signed({2'b00, MinutesMin})) begin
      min_clamped = MinutesMin;
    end else if (min_sum > $signed({2'b00, MinutesMax})) begin
      min_clamped = MinutesMax;
    end else begin
      min_clamped = min_sum[6:0];
    end
    minutes_d = (move && edit_turn) ? min_clamped : minutes_q;
    reload_ms = 23'(minutes_d) * MsPerMin;
  end

  // Tick update, in the order the behavior defines.
  always_comb begin
    remain_d      = remain_q;
    count_run_d   = count_run_q;
    edit_d        = edit_q;
    alarm_d       = alarm_q;
    sw_d          = sw_q;
    sw_run_d      = sw_run_q;
    mode_d        = mode_q;
    held_d        = held_q;
    press_start_d = press_start_q;
    last_short_d  = last_short_q;
    last_move_d   = last_move_q;
    last_alarm_d  = last_alarm_q;
    beep_on_d     = beep_on_q;
    beep_end_d    = beep_end_q;

    if (count_run_q && (remain_q != '0)) remain_d = remain_q - 23'd1;
    if (sw_run_q) sw_d = sw_q + 32'd1;

    if (beep_on_q && (now_q > beep_end_q)) beep_on_d = 1'b0;

    alarm_gap = now_q - last_alarm_q;
    if (alarm_q && (alarm_gap > {16'd0, alarm_repeat_q})) begin
      beep_on_d    = 1'b1;
      beep_end_d   = now_q + AlarmBeepMs;
      last_alarm_d = now_q;
    end

    if (move) begin
      last_move_d = now_q;
      if (edit_turn) begin
        remain_d = reload_ms;
      end else if (move_up) begin
        mode_d = (mode_q == MODE_SETTINGS) ? MODE_CLOCK : mode_e'(mode_q + 3'd1);
      end else begin
        mode_d = (mode_q == MODE_CLOCK) ? MODE_SETTINGS : mode_e'(mode_q - 3'd1);
      end
      beep_on_d  = 1'b1;
      beep_end_d = now_q + TurnBeepMs;
    end

    hold_dur     = now_q - press_start_q;
    short_gap    = now_q - last_short_q;
    release_evt  = !in_data_i.button_down && held_q;
    hold_is_long = hold_dur > {16'd0, hold_limit_q};
    short_ok     = short_gap > {16'd0, debounce_q};

    if (in_data_i.button_down && !held_q) begin
      held_d        = 1'b1;
      press_start_d = now_q;
    end

    if (release_evt) begin
      if (hold_is_long) begin
        if (mode_d == MODE_STOPWATCH) begin
          sw_run_d = 1'b0;
          sw_d     = '0;
        end
        if (mode_d == MODE_TIMER) begin
          if (count_run_q) begin
            count_run_d = 1'b0;
            remain_d    = reload_ms;
          end else begin
            count_run_d = 1'b1;
          end
        end
      end else if (short_ok) begin
        if (mode_d == MODE_TIMER) begin
          priority if (alarm_q) begin
            alarm_d = 1'b0;
          end else if (count_run_q) begin
            count_run_d = 1'b0;
          end else begin
            edit_d = !edit_q;
          end
        end else if (mode_d == MODE_STOPWATCH) begin
          sw_run_d = !sw_run_q;
        end
        last_short_d = now_q;
      end
      held_d = 1'b0;
      // The release beep replaces any earlier beep end time of this tick.
      beep_on_d  = 1'b1;
      beep_end_d = now_q + ReleaseBeepMs;
    end

    if (count_run_d && (remain_d == '0)) begin
      count_run_d = 1'b0;
      alarm_d     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q         <= '0;
      quad_q        <= '0;
      detent_q      <= '0;
      last_move_q   <= '0;
      mode_q        <= MODE_CLOCK;
      minutes_q     <= MinutesReset;
      remain_q      <= RemainReset;
      count_run_q   <= 1'b0;
      edit_q        <= 1'b0;
      alarm_q       <= 1'b0;
      last_alarm_q  <= '0;
      sw_q          <= '0;
      sw_run_q      <= 1'b0;
      held_q        <= 1'b0;
      press_start_q <= '0;
      last_short_q  <= '0;
      beep_on_q     <= 1'b0;
      beep_end_q    <= '0;
    end else if (in_accept) begin
      now_q         <= now_q + 32'd1;
      quad_q        <= quad_d;
      detent_q      <= detent_d;
      last_move_q   <= last_move_d;
      mode_q        <= mode_d;
      minutes_q     <= minutes_d;
      remain_q      <= remain_d;
      count_run_q   <= count_run_d;
      edit_q        <= edit_d;
      alarm_q       <= alarm_d;
      last_alarm_q  <= last_alarm_d;
      sw_q          <= sw_d;
      sw_run_q      <= sw_run_d;
      held_q        <= held_d;
      press_start_q <= press_start_d;
      last_short_q  <= last_short_d;
      beep_on_q     <= beep_on_d;
      beep_end_q    <= beep_end_d;
    end
  end

  // The state only moves when the previous result has left, so the result
  // item is read straight from the state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    out_data_o.mode               = mode_q;
    out_data_o.timer_minutes      = minutes_q;
    out_data_o.timer_remaining_ms = remain_q;
    out_data_o.timer_running      = count_run_q;
    out_data_o.timer_editing      = edit_q;
    out_data_o.alarm_active       = alarm_q;
    out_data_o.stopwatch_ms       = sw_q;
    out_data_o.stopwatch_running  = sw_run_q;
    out_data_o.buzzer             = beep_on_q;
    out_data_o.button_held        = held_q;
  end

endmodule
